### rtl/sha1p_pkg.sv
// Package for the SHA-1 engine with preset state and length register.
// Holds the beat structs, register indexes and SHA-1 constants; no dependencies.
package sha1p_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       no_byte;
        logic       is_last;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    localparam logic [2:0] REG_USE_PRESET = 3'd0;
    localparam logic [2:0] REG_PRESET_A   = 3'd1;
    localparam logic [2:0] REG_PRESET_B   = 3'd2;
    localparam logic [2:0] REG_PRESET_C   = 3'd3;
    localparam logic [2:0] REG_PRESET_D   = 3'd4;
    localparam logic [2:0] REG_PRESET_E   = 3'd5;
    localparam logic [2:0] REG_LENGTH     = 3'd6;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Control from the sequencer to the round datapath.
    typedef struct packed {
        logic       init;
        logic       load_work;
        logic       round_en;
        logic [6:0] round;
        logic       fold;
    } rnd_ctrl_t;

endpackage

### rtl/sha1p_round.sv
// SHA-1 round datapath: working words, chaining words and the final add.
// Depends on sha1p_pkg.
module sha1p_round (
    input  logic                  aclk,
    input  sha1p_pkg::rnd_ctrl_t  ctrl,
    input  logic [159:0]          init_words,
    input  logic [31:0]           w_word,
    output logic [159:0]          chain
);
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [159:0] chain_reg;
    logic [31:0] f, k, t;

    always_comb begin
        if (ctrl.round < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1p_pkg::K0;
        end else if (ctrl.round < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1p_pkg::K1;
        end else if (ctrl.round < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1p_pkg::K2;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1p_pkg::K3;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_word;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.init) begin
            chain_reg <= init_words;
        end else if (ctrl.fold) begin
            chain_reg <= {chain_reg[159:128] + a_reg, chain_reg[127:96] + b_reg,
                          chain_reg[95:64] + c_reg, chain_reg[63:32] + d_reg,
                          chain_reg[31:0] + e_reg};
        end
        if (ctrl.load_work) begin
            {a_reg, b_reg, c_reg, d_reg, e_reg} <= chain_reg;
        end else if (ctrl.round_en) begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
        end
    end

    assign chain = chain_reg;
endmodule

### rtl/sha1_with_preset_state_and_length_top.sv
// Top level of the SHA-1 engine: byte packing, block-word memory, sequencer.
// Depends on sha1p_pkg and sha1p_round.
//
// Each message byte takes one beat. Every 64th byte starts a compression of 80
// rounds over the 16-word schedule memory, which has a registered read port.
// Rounds 0 to 15 each take a read, then a round. Rounds 16 to 79 each take three
// tap reads, then a round and write-back. A load of the working words comes first
// and a fold into the chaining words last. Input is held off while a block is
// compressed. A last beat writes the marker word and the fill at one word per cycle,
// compresses one or two padded blocks and then offers five digest beats. No
// clearing pass is needed after reset.
module sha1_with_preset_state_and_length_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha1p_pkg::in_beat_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha1p_pkg::out_beat_t  m_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_wdata
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_FOLD  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic         use_preset_reg;
    logic [159:0] preset_reg;
    logic [63:0]  length_reg;

    logic [2:0]  state_reg;
    logic [5:0]  pos_reg;
    logic        started_reg;
    logic        final_reg;   // last beat seen; padded blocks follow
    logic        lastblk_reg; // this padded block carries the length
    logic        mark_reg;    // first fill word holds the marker
    logic [6:0]  round_reg;
    logic [1:0]  tap_reg;
    logic [31:0] acc_reg;
    logic [2:0]  oidx_reg;
    logic [31:0] cur_reg;     // word being packed

    logic [31:0] mem [16];
    logic [31:0] rd_reg;
    logic        we;
    logic [3:0]  waddr, raddr;
    logic [31:0] wdata;

    sha1p_pkg::rnd_ctrl_t ctrl;
    logic [159:0] chain;
    logic [31:0]  w_round;

    // memory
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_preset_reg <= 1'b0;
            preset_reg <= {sha1p_pkg::H0, sha1p_pkg::H1, sha1p_pkg::H2,
                           sha1p_pkg::H3, sha1p_pkg::H4};
            length_reg <= 64'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sha1p_pkg::REG_USE_PRESET: use_preset_reg <= cfg_wdata[0];
                sha1p_pkg::REG_PRESET_A:   preset_reg[159:128] <= cfg_wdata[31:0];
                sha1p_pkg::REG_PRESET_B:   preset_reg[127:96] <= cfg_wdata[31:0];
                sha1p_pkg::REG_PRESET_C:   preset_reg[95:64] <= cfg_wdata[31:0];
                sha1p_pkg::REG_PRESET_D:   preset_reg[63:32] <= cfg_wdata[31:0];
                sha1p_pkg::REG_PRESET_E:   preset_reg[31:0] <= cfg_wdata[31:0];
                sha1p_pkg::REG_LENGTH:     length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic        s_fire;
    logic [31:0] byte_word;
    logic [3:0]  s;
    logic [1:0]  sub;
    logic [31:0] sched;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign s   = round_reg[3:0];
    assign sched = acc_reg ^ rd_reg;
    assign sub = pos_reg[1:0];

    always_comb begin
        byte_word = cur_reg;
        unique case (sub)
            2'd0: byte_word = {s_data.data_byte, 24'd0};
            2'd1: byte_word[23:16] = s_data.data_byte;
            2'd2: byte_word[15:8] = s_data.data_byte;
            2'd3: byte_word[7:0] = s_data.data_byte;
            default: ;
        endcase
    end

    // marker position and the word that carries it
    logic [5:0]  mark_pos;
    logic [31:0] mark_word;
    always_comb begin
        mark_pos  = s_data.no_byte ? pos_reg : pos_reg + 6'd1;
        mark_word = s_data.no_byte ? cur_reg : byte_word;
        unique case (mark_pos[1:0])
            2'd0: mark_word = 32'h80000000;
            2'd1: mark_word[23:0] = 24'h800000;
            2'd2: mark_word[15:0] = 16'h8000;
            2'd3: mark_word[7:0] = 8'h80;
            default: ;
        endcase
    end

    // fill word at pos_reg: marker word first, then zeros, length in the last two of the block that carries it
    logic [31:0] pad_word;
    always_comb begin
        pad_word = 32'd0;
        if (mark_reg) pad_word = cur_reg;
        else if (lastblk_reg && pos_reg[5:2] == 4'd14) pad_word = length_reg[63:32];
        else if (lastblk_reg && pos_reg[5:2] == 4'd15) pad_word = length_reg[31:0];
    end

    // memory port control
    always_comb begin
        we = 1'b0; waddr = pos_reg[5:2]; wdata = byte_word;
        raddr = s;
        ctrl = '0;
        ctrl.round = round_reg;
        w_round = rd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                we = s_fire && !s_data.no_byte;
                ctrl.init = s_fire && !started_reg;
            end
            ST_PAD: begin
                we = 1'b1; wdata = pad_word;
            end
            ST_LOAD: begin
                ctrl.load_work = 1'b1;
                raddr = 4'd13;
            end
            ST_RD: begin
                if (round_reg < 7'd16) begin
                    raddr = s;
                end else begin
                    // read phase: pick next tap
                    unique case (tap_reg)
                        2'd0: raddr = s + 4'd8;
                        2'd1: raddr = s + 4'd2;
                        2'd2: raddr = s;
                        default: raddr = s;
                    endcase
                end
            end
            ST_WR: begin
                raddr = s + 4'd1 + 4'd13;
                waddr = s;
                if (round_reg < 7'd16) begin
                    w_round = rd_reg;
                end else begin
                    w_round = {sched[30:0], sched[31]};
                    we = 1'b1;
                    wdata = w_round;
                end
                ctrl.round_en = 1'b1;
            end
            ST_FOLD: ctrl.fold = 1'b1;
            default: ;
        endcase
    end

    // the RD state reads three taps (s+8, s+2, s) one per cycle, after s+13 was read in
    // the previous cycle; rounds below 16 read only tap s
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg <= 6'd0;
            started_reg <= 1'b0;
            final_reg <= 1'b0;
            lastblk_reg <= 1'b0;
            mark_reg <= 1'b0;
            round_reg <= 7'd0;
            tap_reg <= 2'd0;
            oidx_reg <= 3'd0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        started_reg <= 1'b1;
                        if (s_data.is_last) begin
                            final_reg <= 1'b1;
                            mark_reg <= 1'b1;
                            if (!s_data.no_byte && pos_reg == 6'd63) begin
                                // marker opens the next block
                                cur_reg <= 32'h80000000;
                                pos_reg <= 6'd0;
                                state_reg <= ST_LOAD;
                            end else begin
                                cur_reg <= mark_word;
                                pos_reg <= {mark_pos[5:2], 2'b00};
                                lastblk_reg <= (mark_pos < 6'd56);
                                state_reg <= ST_PAD;
                            end
                        end else if (!s_data.no_byte) begin
                            cur_reg <= byte_word;
                            pos_reg <= pos_reg + 6'd1;
                            if (pos_reg == 6'd63) state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_PAD: begin
                    mark_reg <= 1'b0;
                    pos_reg <= pos_reg + 6'd4;
                    if (pos_reg == 6'd60) state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    round_reg <= 7'd0;
                    tap_reg <= 2'd0;
                    acc_reg <= 32'd0;
                    state_reg <= ST_RD;
                end
                ST_RD: begin
                    if (round_reg < 7'd16) begin
                        tap_reg <= 2'd0;
                        state_reg <= ST_WR;
                    end else begin
                        acc_reg <= acc_reg ^ rd_reg;
                        if (tap_reg == 2'd2) begin
                            tap_reg <= 2'd0;
                            state_reg <= ST_WR;
                        end else begin
                            tap_reg <= tap_reg + 2'd1;
                        end
                    end
                end
                ST_WR: begin
                    acc_reg <= 32'd0;
                    round_reg <= round_reg + 7'd1;
                    state_reg <= (round_reg == 7'd79) ? ST_FOLD : ST_RD;
                end
                ST_FOLD: begin
                    if (!final_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (!lastblk_reg) begin
                        lastblk_reg <= 1'b1;
                        pos_reg <= 6'd0;
                        state_reg <= ST_PAD;
                    end else begin
                        oidx_reg <= 3'd0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd4) begin
                            state_reg <= ST_IDLE;
                            started_reg <= 1'b0;
                            final_reg <= 1'b0;
                            lastblk_reg <= 1'b0;
                            pos_reg <= 6'd0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    sha1p_round u_round (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .init_words (use_preset_reg ? preset_reg :
                     {sha1p_pkg::H0, sha1p_pkg::H1, sha1p_pkg::H2,
                      sha1p_pkg::H3, sha1p_pkg::H4}),
        .w_word     (w_round),
        .chain      (chain)
    );

    logic [159:0] sh;
    assign sh = chain << {oidx_reg, 5'd0};
    assign m_valid = (state_reg == ST_OUT);
    assign m_data.digest_word = sh[159:128];
    assign m_data.word_index = oidx_reg;
    assign m_data.last_word = (oidx_reg == 3'd4);
endmodule
